FILE: src/bit_field_packer_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bit field packer
// Shared forms for the concurrent checks, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef BIT_FIELD_PACKER_CORE_DEFINES_SVH
`define BIT_FIELD_PACKER_CORE_DEFINES_SVH

// Same-cycle implication.
`define BFP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BFP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/bfp_pkg.sv
// ----------------------------------------------------------------------------
// bfp_pkg
// Operation codes, fixed field widths and sequencer states of the packer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bfp_pkg;

  localparam int OP_W     = 2;
  localparam int OFFSET_W = 15;
  localparam int FWIDTH_W = 7;
  localparam int VALUE_W  = 64;
  localparam int RADDR_W  = 12;
  localparam int BYTE_W   = 8;
  localparam int POS_O_W  = 16;
  localparam int USED_O_W = 13;

  // Widest field in bits; wider requests saturate to this.
  localparam logic [FWIDTH_W-1:0] MAX_FIELD = 7'd64;

  localparam logic [OP_W-1:0] OP_WRITE  = 2'd0;
  localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_W-1:0] OP_ALIGN  = 2'd2;
  localparam logic [OP_W-1:0] OP_READ   = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_PREP,
    ST_RMW,
    ST_DONE
  } bfp_state_t;

endpackage

FILE: src/bit_field_packer_core.sv
// ----------------------------------------------------------------------------
// bit_field_packer_core
// Packs 0..64-bit fields LSB first into a byte-wide store; reads bytes back.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one operation per item: write a
//   field at in_start_bit, append a field at the running position, align
//   the position to a byte, or read the byte at in_read_addr. Every item
//   gives exactly one result item on out_valid/out_ready with the byte read,
//   the running position, the high-water size in bytes and a status bit
//   that flags a write that would pass the end of the store (skipped).
//   Pacing: the block works one item at a time. An item that writes a
//   field touching n bytes (1..9) passes through the RMW state byte by
//   byte; align, read, zero width and skipped writes go from PREP to DONE.
//   The pace is set by the single byte-wide store RAM: one byte
//   read-modify-write per cycle, the read of the next byte overlapping
//   the write of the current one. The result is registered in DONE.
//   Reset: a pass clears all STORE_BYTES bytes of the store, one byte a
//   cycle; in_ready stays low until it ends. Position and size reset to 0.
//   Stall: a result waiting on out_ready holds in the output register; the
//   next item may be accepted and worked, and its result waits until the
//   register frees.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bit_field_packer_core
  import bfp_pkg::*;
#(
  parameter int STORE_BYTES = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [OP_W-1:0]     in_op,
  input  logic [OFFSET_W-1:0] in_start_bit,
  input  logic [FWIDTH_W-1:0] in_field_width,
  input  logic [VALUE_W-1:0]  in_field_value,
  input  logic [RADDR_W-1:0]  in_read_addr,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [BYTE_W-1:0]   out_read_data,
  output logic [POS_O_W-1:0]  out_write_pos,
  output logic [USED_O_W-1:0] out_used_bytes,
  output logic                out_status
);

  // Address, position and size widths follow from the store depth.
  localparam int AW       = $clog2(STORE_BYTES);
  localparam int CAP_BITS = STORE_BYTES * 8;
  localparam int PW       = $clog2(CAP_BITS + 1);
  localparam int SW       = $clog2(STORE_BYTES + 1);
  localparam int FW       = (PW > OFFSET_W) ? PW : OFFSET_W;
  localparam int EW       = FW + 1;
  localparam int LANE_W   = VALUE_W + BYTE_W;

  bfp_state_t state_r, state_nxt;

  // Control state
  logic [AW-1:0]          clr_addr_r;
  logic [PW-1:0]          pos_r;
  logic [SW-1:0]          size_r;
  logic                   out_valid_r;

  // Item payload and work registers
  logic [OP_W-1:0]        op_r;
  logic [OFFSET_W-1:0]    off_r;
  logic [FWIDTH_W-1:0]    width_r;
  logic [VALUE_W-1:0]     value_r;
  logic [RADDR_W-1:0]     raddr_r;
  logic                   rd_ok_r;
  logic                   status_r;
  logic [LANE_W-1:0]      data_r;
  logic [LANE_W-1:0]      mask_r;
  logic [AW-1:0]          wr_addr_r;
  logic [3:0]             cnt_r;
  logic [BYTE_W-1:0]      out_read_data_r;
  logic [POS_O_W-1:0]     out_write_pos_r;
  logic [USED_O_W-1:0]    out_used_bytes_r;
  logic                   out_status_r;

  // RAM port signals
  logic                   ram_we;
  logic [AW-1:0]          ram_waddr;
  logic [BYTE_W-1:0]      ram_wdata;
  logic                   ram_re;
  logic [AW-1:0]          ram_raddr;
  logic [BYTE_W-1:0]      ram_rdata;

  // Decode of the current item
  logic                   is_write;
  logic [FW-1:0]          first_bit;
  logic [EW-1:0]          end_bit;
  logic [EW-1:0]          end_round;
  logic                   over;
  logic                   skip;
  logic [SW-1:0]          needed;
  logic [6:0]             span_bits;
  logic [3:0]             nbytes;
  logic [VALUE_W-1:0]     vmask;
  logic [LANE_W-1:0]      data_sh;
  logic [LANE_W-1:0]      mask_sh;
  logic [AW-1:0]          first_byte;
  logic [PW:0]            align_sum;
  logic [PW-1:0]          pos_aligned;
  logic                   rd_in_range;
  logic                   load_out;

  // --------------------------------------------------------------------------
  // Item decode: position, end bit, capacity check, byte span and lanes
  // --------------------------------------------------------------------------
  always_comb begin
    is_write  = (op_r == OP_WRITE) || (op_r == OP_APPEND);
    first_bit = (op_r == OP_APPEND) ? FW'(pos_r) : FW'(off_r);
    end_bit   = EW'(first_bit) + EW'(width_r);
    end_round = end_bit + EW'(7);
    over      = end_bit > EW'(CAP_BITS);
    skip      = (width_r == '0) || over;
    needed    = end_round[3 +: SW];
    span_bits = 7'(first_bit[2:0]) + width_r + 7'd7;
    nbytes    = span_bits[6:3];
    vmask     = width_r[6] ? '1 : ((VALUE_W'(1) << width_r[5:0]) - VALUE_W'(1));
    data_sh   = LANE_W'(value_r & vmask) << first_bit[2:0];
    mask_sh   = LANE_W'(vmask) << first_bit[2:0];
    first_byte = AW'(first_bit >> 3);
    align_sum   = (PW + 1)'(pos_r) + (PW + 1)'(7);
    pos_aligned = {align_sum[PW-1:3], 3'b000};
    rd_in_range = 32'(raddr_r) < 32'(STORE_BYTES);
  end

  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ready);

  // --------------------------------------------------------------------------
  // Sequencer: next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == AW'(STORE_BYTES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_PREP;
        end
      end
      ST_PREP: begin
        state_nxt = (is_write && !skip) ? ST_RMW : ST_DONE;
      end
      ST_RMW: begin
        if (cnt_r == 4'd1) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // --------------------------------------------------------------------------
  // Sequencer: outputs (handshake and RAM ports)
  // --------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = wr_addr_r;
    ram_wdata = (ram_rdata & ~mask_r[BYTE_W-1:0]) | data_r[BYTE_W-1:0];
    ram_re    = 1'b0;
    ram_raddr = wr_addr_r + AW'(1);
    unique case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr_r;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
      end
      ST_PREP: begin
        // Issue the first read: the field's first byte or the byte to read back.
        if (op_r == OP_READ) begin
          ram_re    = rd_in_range;
          ram_raddr = AW'(raddr_r);
        end else begin
          ram_re    = is_write && !skip;
          ram_raddr = first_byte;
        end
      end
      ST_RMW: begin
        // Write back the merged byte; fetch the next one in the same cycle.
        ram_we = 1'b1;
        ram_re = cnt_r > 4'd1;
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Control registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_addr_r  <= '0;
      pos_r       <= '0;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + AW'(1);
      end
      if (state_r == ST_PREP) begin
        // Commit position and size now; the bytes follow in the RMW pass.
        if (is_write && !skip) begin
          if (needed > size_r) begin
            size_r <= needed;
          end
          if (op_r == OP_APPEND) begin
            pos_r <= pos_r + PW'(width_r);
          end
        end else if (op_r == OP_ALIGN) begin
          pos_r <= pos_aligned;
        end
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Payload registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      op_r    <= in_op;
      off_r   <= in_start_bit;
      width_r <= (in_field_width > MAX_FIELD) ? MAX_FIELD : in_field_width;
      value_r <= in_field_value;
      raddr_r <= in_read_addr;
    end
    if (state_r == ST_PREP) begin
      status_r  <= is_write && (width_r != '0) && over;
      rd_ok_r   <= rd_in_range;
      data_r    <= data_sh;
      mask_r    <= mask_sh;
      wr_addr_r <= first_byte;
      cnt_r     <= nbytes;
    end
    if (state_r == ST_RMW) begin
      // Advance to the next byte lane.
      data_r    <= data_r >> BYTE_W;
      mask_r    <= mask_r >> BYTE_W;
      wr_addr_r <= wr_addr_r + AW'(1);
      cnt_r     <= cnt_r - 4'd1;
    end
    if (load_out) begin
      out_read_data_r  <= ((op_r == OP_READ) && rd_ok_r) ? ram_rdata : '0;
      out_write_pos_r  <= POS_O_W'(pos_r);
      out_used_bytes_r <= USED_O_W'(size_r);
      out_status_r     <= status_r;
    end
  end

  // --------------------------------------------------------------------------
  // Byte store
  // --------------------------------------------------------------------------
  bfp_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid      = out_valid_r;
  assign out_read_data  = out_read_data_r;
  assign out_write_pos  = out_write_pos_r;
  assign out_used_bytes = out_used_bytes_r;
  assign out_status     = out_status_r;

endmodule

FILE: src/bfp_ram.sv
// ----------------------------------------------------------------------------
// bfp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // Read data holds while no read is issued.
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/bfp_checker.sv
// ----------------------------------------------------------------------------
// bfp_checker
// Port-level checks of the packer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "bit_field_packer_core_defines.svh"

module bfp_checker
  import bfp_pkg::*;
(
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_ready,
  input logic                out_valid,
  input logic                out_ready,
  input logic [BYTE_W-1:0]   out_read_data,
  input logic [POS_O_W-1:0]  out_write_pos,
  input logic [USED_O_W-1:0] out_used_bytes,
  input logic                out_status
);

  logic                seen_r;
  logic [POS_O_W-1:0]  prev_pos_r;
  logic [USED_O_W-1:0] prev_used_r;

  // Hold the position and size of the last delivered item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (out_valid && out_ready) begin
      seen_r      <= 1'b1;
      prev_pos_r  <= out_write_pos;
      prev_used_r <= out_used_bytes;
    end
  end

  `BFP_ASSERT_IMP(a_skip_reads_zero, out_valid && out_status, out_read_data == 8'd0, "skipped write returned data")
  `BFP_ASSERT_IMP(a_skip_keeps_state, out_valid && out_status && seen_r, (out_write_pos == prev_pos_r) && (out_used_bytes == prev_used_r), "skipped write changed position or size")
  `BFP_ASSERT_NXT(a_one_item, in_valid && in_ready, !in_ready, "second item taken while one is in work")
  `BFP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_write_pos) && $stable(out_read_data), "stalled result changed")

endmodule

bind bit_field_packer_core bfp_checker u_bfp_checker (.*);

FILE: test/tb_bit_field_packer_core.sv
// ----------------------------------------------------------------------------
// tb_bit_field_packer_core
// Self-checking bench for the bit field packer: a queue-fed driver, a
// monitor that checks every result item against a bit-level shadow of the
// byte store, and several idle and stall settings on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bit_field_packer_core;
  import bfp_pkg::*;

  localparam int STORE_BYTES = 4096;
  localparam int STORE_BITS  = STORE_BYTES * 8;
  localparam int MAX_PRINTS  = 40;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [OFFSET_W-1:0] start_bit;
    logic [FWIDTH_W-1:0] field_width;
    logic [VALUE_W-1:0]  field_value;
    logic [RADDR_W-1:0]  read_addr;
  } pack_item_t;

  typedef struct packed {
    logic [BYTE_W-1:0]   read_data;
    logic [POS_O_W-1:0]  write_pos;
    logic [USED_O_W-1:0] used_bytes;
    logic                status;
  } pack_result_t;

  // Clock, reset and every block input start at known values.
  logic                clk            = 1'b0;
  logic                rst_n          = 1'b0;
  logic                in_valid       = 1'b0;
  logic [OP_W-1:0]     in_op          = OP_READ;
  logic [OFFSET_W-1:0] in_start_bit   = '0;
  logic [FWIDTH_W-1:0] in_field_width = '0;
  logic [VALUE_W-1:0]  in_field_value = '0;
  logic [RADDR_W-1:0]  in_read_addr   = '0;
  logic                out_ready      = 1'b0;
  logic                in_ready;
  logic                out_valid;
  logic [BYTE_W-1:0]   out_read_data;
  logic [POS_O_W-1:0]  out_write_pos;
  logic [USED_O_W-1:0] out_used_bytes;
  logic                out_status;

  // Shadow state of the packer: byte store, running position, high-water size.
  logic [7:0]  store_model [STORE_BYTES];
  logic [16:0] pos_model;
  logic [13:0] size_model;

  pack_item_t   pending_items[$];
  pack_result_t due_results[$];
  pack_item_t   bus_item;
  pack_result_t next_due;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;

  always #4 clk = ~clk;

  bit_field_packer_core #(
    .STORE_BYTES(STORE_BYTES)
  ) uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_op         (in_op),
    .in_start_bit  (in_start_bit),
    .in_field_width(in_field_width),
    .in_field_value(in_field_value),
    .in_read_addr  (in_read_addr),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_read_data (out_read_data),
    .out_write_pos (out_write_pos),
    .out_used_bytes(out_used_bytes),
    .out_status    (out_status)
  );

  // Print one line per mismatch (capped to keep the log short) and count it.
  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (error_count < MAX_PRINTS)
      $display("%0t mismatch on %s: got 'h%0h, want 'h%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Write the low w bits of v starting at bit 'first'; return 1 if the field
  // would run past the end of the store, in which case nothing changes.
  function automatic logic store_field(int unsigned first, int unsigned w,
                                       logic [63:0] v);
    int unsigned bit_ix;
    int unsigned end_byte;
    if (w == 0) return 1'b0;
    if (first + w > STORE_BITS) return 1'b1;
    for (int unsigned i = 0; i < w; i++) begin
      bit_ix = first + i;
      store_model[bit_ix >> 3][bit_ix % 8] = v[i];
    end
    end_byte = (first + w + 7) >> 3;
    if (end_byte > size_model) size_model = end_byte[13:0];
    return 1'b0;
  endfunction

  // Advance the shadow state by one item and return the result it must give.
  function automatic pack_result_t apply_op(pack_item_t it);
    pack_result_t r;
    int unsigned  w;
    r = '0;
    w = 32'((it.field_width > MAX_FIELD) ? MAX_FIELD : it.field_width);
    case (it.op)
      OP_WRITE: r.status = store_field(32'(it.start_bit), w, it.field_value);
      OP_APPEND: begin
        r.status = store_field(32'(pos_model), w, it.field_value);
        if (!r.status) pos_model = pos_model + 17'(w);
      end
      OP_ALIGN: pos_model = (pos_model + 17'd7) & ~17'd7;
      default: begin
        if (it.read_addr < STORE_BYTES) r.read_data = store_model[it.read_addr];
      end
    endcase
    r.write_pos  = pos_model[POS_O_W-1:0];
    r.used_bytes = size_model[USED_O_W-1:0];
    return r;
  endfunction

  // Driver: predict the accepted item, then load the next one unless the
  // sender idles; hold the payload while the block is not ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        due_results.push_back(apply_op(bus_item));
      end
      if (!in_valid || in_ready) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          bus_item = pending_items.pop_front();
          in_op          <= bus_item.op;
          in_start_bit   <= bus_item.start_bit;
          in_field_width <= bus_item.field_width;
          in_field_value <= bus_item.field_value;
          in_read_addr   <= bus_item.read_addr;
          in_valid       <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each accepted result item against the oldest one due,
  // then decide whether to stall the next cycle.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_mismatch("unexpected result item", 64'd0, 64'd0);
        end else begin
          next_due = due_results.pop_front();
          if (out_read_data !== next_due.read_data)
            report_mismatch("read_data", 64'(out_read_data), 64'(next_due.read_data));
          if (out_write_pos !== next_due.write_pos)
            report_mismatch("write_pos", 64'(out_write_pos), 64'(next_due.write_pos));
          if (out_used_bytes !== next_due.used_bytes)
            report_mismatch("used_bytes", 64'(out_used_bytes),
                            64'(next_due.used_bytes));
          if (out_status !== next_due.status)
            report_mismatch("status", 64'(out_status), 64'(next_due.status));
        end
      end
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_item(logic [OP_W-1:0] op, int unsigned offset, int unsigned width,
                           logic [63:0] value, int unsigned addr);
    pack_item_t it;
    it.op          = op;
    it.start_bit   = offset[OFFSET_W-1:0];
    it.field_width = width[FWIDTH_W-1:0];
    it.field_value = value;
    it.read_addr   = addr[RADDR_W-1:0];
    pending_items.push_back(it);
  endtask

  // General random item: unused fields carry noise, write offsets cluster
  // low (so fields overlap) or near the top of the store.
  function automatic pack_item_t random_item();
    pack_item_t  it;
    int unsigned pick;
    it.op          = OP_READ;
    it.start_bit   = OFFSET_W'($urandom);
    it.field_value = {$urandom, $urandom};
    it.read_addr   = RADDR_W'($urandom);
    case ($urandom_range(3))
      0: it.field_width = FWIDTH_W'($urandom_range(8));
      1: it.field_width = FWIDTH_W'($urandom_range(64));
      2: it.field_width = MAX_FIELD;
      default: it.field_width = FWIDTH_W'($urandom_range(127));
    endcase
    case ($urandom_range(7))
      0: it.field_value = '1;
      1: it.field_value = '0;
      default: ;
    endcase
    pick = $urandom_range(99);
    if (pick < 35) begin
      it.op = OP_WRITE;
      case ($urandom_range(3))
        0, 1: it.start_bit = OFFSET_W'($urandom_range(1023));
        2: it.start_bit = OFFSET_W'($urandom_range(STORE_BITS - 1, STORE_BITS - 80));
        default: ;
      endcase
    end else if (pick < 65) begin
      it.op = OP_APPEND;
    end else if (pick < 75) begin
      it.op = OP_ALIGN;
    end else if ($urandom_range(1) == 0) begin
      it.read_addr = RADDR_W'($urandom_range(127));
    end
    return it;
  endfunction

  // Fill run: mostly wide appends, enough to drive the position to the end
  // of the store, with reads of what was packed mixed in.
  function automatic pack_item_t fill_item();
    pack_item_t  it;
    int unsigned pick;
    it = random_item();
    pick = $urandom_range(99);
    if (pick < 85) begin
      it.op = OP_APPEND;
      it.field_width = ($urandom_range(9) == 0) ? 7'd127 : 7'($urandom_range(64, 60));
    end else if (pick < 93) begin
      it.op = OP_READ;
      it.read_addr = RADDR_W'($urandom);
    end else if (pick < 97) begin
      it.op = OP_ALIGN;
    end
    return it;
  endfunction

  // Hold until every queued item is accepted and every result item is back.
  task automatic drain();
    while (pending_items.size() != 0 || in_valid || due_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 56, 0, 17};
    recv_pct = '{0, 0, 56, 17};

    for (int i = 0; i < STORE_BYTES; i++) store_model[i] = 8'h00;
    pos_model  = '0;
    size_model = '0;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: field extremes, every op, zero width, saturated width,
    // capacity edge, alignment and value masking.
    push_item(OP_READ,   0,     0,   64'hDEAD_BEEF, 0);
    push_item(OP_WRITE,  0,     64,  '1,            0);
    push_item(OP_READ,   0,     0,   0,             0);
    push_item(OP_WRITE,  3,     64,  64'h0123_4567_89AB_CDEF, 0);
    push_item(OP_READ,   0,     0,   0,             0);
    push_item(OP_READ,   0,     0,   0,             8);
    push_item(OP_WRITE,  5,     0,   '1,            0);
    push_item(OP_APPEND, 0,     0,   '1,            0);
    push_item(OP_APPEND, 0,     13,  '1,            0);
    push_item(OP_ALIGN,  0,     0,   0,             0);
    push_item(OP_ALIGN,  0,     0,   0,             0);
    push_item(OP_APPEND, 0,     127, 64'hC3C3_5A5A_0F0F_9696, 0);
    push_item(OP_READ,   0,     0,   0,             3);
    push_item(OP_WRITE,  32767, 1,   64'h1,         0);
    push_item(OP_WRITE,  32767, 2,   '1,            0);
    push_item(OP_WRITE,  32704, 64,  64'hA5A5_A5A5_A5A5_A5A5, 0);
    push_item(OP_WRITE,  32705, 64,  '1,            0);
    push_item(OP_READ,   0,     0,   0,             4095);
    push_item(OP_READ,   0,     0,   0,             4088);
    push_item(OP_WRITE,  100,   7,   64'hFFFF_FFFF_FFFF_FF80, 0);
    push_item(OP_READ,   0,     0,   0,             12);
    push_item(OP_APPEND, 0,     1,   64'hFFFF_FFFF_FFFF_FFFE, 0);
    push_item(OP_WRITE,  0,     65,  64'h8000_0000_0000_0001, 0);
    push_item(OP_READ,   0,     0,   0,             2);
    // Hold the sender until every result is back.
    drain();

    // Random part, one idle/stall setting per phase; the last phase ends
    // with a fill run that reaches the end of the store and then probes it.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = send_pct[ph];
      recv_stall_pct = recv_pct[ph];
      for (int n = 0; n < 330; n++) pending_items.push_back(random_item());
      if (ph == 3) begin
        for (int n = 0; n < 450; n++) pending_items.push_back(fill_item());
        for (int n = 0; n < 60; n++) pending_items.push_back(random_item());
      end
      drain();
    end

    // Let any stray result item surface before the verdict.
    repeat (20) @(negedge clk);
    if (error_count == 0) begin
      $display("bit_field_packer_core regression: pass");
    end else begin
      $display("bit_field_packer_core regression: fail");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run, including the store clear.
  initial begin
    #10_000_000;
    $display("bit_field_packer_core regression: fail");
    $finish;
  end

endmodule
